[rtl/nzs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nzs_pkg: shared types and constants for the nearest zone search
// Field widths, beat layout, zone entry format and sequencer states.
// ----------------------------------------------------------------------------
package nzs_pkg;

    localparam int COORD_W    = 16;
    localparam int SURF_W     = 3;
    localparam int SLOT_W     = 3;
    localparam int POSTURE_W  = 3;
    localparam int DIST_W     = 34;
    localparam int SQ_W       = 2 * COORD_W;
    localparam int SLOT_COUNT = 2 ** SLOT_W;

    localparam int S_TDATA_W  = 64;
    localparam int M_TDATA_W  = 40;
    localparam int M_PAD_W    = M_TDATA_W - DIST_W - SLOT_W;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                       valid;
        logic                       uses_surface;
        logic [SURF_W-1:0]          surface;
        logic signed [COORD_W-1:0]  z;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  x;
    } t_zone;

    typedef struct packed {
        logic [SURF_W-1:0]          surface;
        logic signed [COORD_W-1:0]  z;
        logic signed [COORD_W-1:0]  y;
        logic signed [COORD_W-1:0]  x;
    } t_hit;

    typedef struct packed {
        logic                valid;
        logic                eligible;
        logic [SLOT_W-1:0]   slot;
        logic [DIST_W-1:0]   dist_sq;
    } t_dist_res;

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_RESULT = 5'b10000
    } t_state;

endpackage

[rtl/nzs_dist.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nzs_dist: squared distance and eligibility unit
// Three-stage pipeline shared by every zone of a scan: absolute differences,
// squares, then the 34-bit sum. Takes one zone per cycle.
// ----------------------------------------------------------------------------
module nzs_dist
    import nzs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [SLOT_W-1:0]  i_slot,
    input  t_zone              i_entry,
    input  t_hit               i_hit,
    output t_dist_res          o_res,
    output logic               o_busy
);

    function automatic logic [COORD_W-1:0] f_absdiff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
        return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
    endfunction

    logic               r_a_v, r_b_v, r_c_v;
    logic               r_a_elig, r_b_elig, r_c_elig;
    logic [SLOT_W-1:0]  r_a_slot, r_b_slot, r_c_slot;
    logic [COORD_W-1:0] r_ax, r_ay, r_az;
    logic [SQ_W-1:0]    r_bx, r_by, r_bz;
    logic [DIST_W-1:0]  r_c_dist;
    logic               w_elig;

    assign w_elig = i_entry.valid &&
                    (!i_entry.uses_surface || (i_entry.surface == i_hit.surface));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_elig <= w_elig;
        r_a_slot <= i_slot;
        r_ax     <= f_absdiff(i_entry.x, i_hit.x);
        r_ay     <= f_absdiff(i_entry.y, i_hit.y);
        r_az     <= f_absdiff(i_entry.z, i_hit.z);

        r_b_elig <= r_a_elig;
        r_b_slot <= r_a_slot;
        r_bx     <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_by     <= SQ_W'(r_ay) * SQ_W'(r_ay);
        r_bz     <= SQ_W'(r_az) * SQ_W'(r_az);

        r_c_elig <= r_b_elig;
        r_c_slot <= r_b_slot;
        r_c_dist <= DIST_W'(r_bx) + DIST_W'(r_by) + DIST_W'(r_bz);
    end

    assign o_res.valid    = r_c_v;
    assign o_res.eligible = r_c_elig;
    assign o_res.slot     = r_c_slot;
    assign o_res.dist_sq  = r_c_dist;
    assign o_busy         = r_a_v | r_b_v | r_c_v;

endmodule

[rtl/nearest_zone_search_with_surface_filter_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_zone_search_with_surface_filter_top
// Per-posture zone tables with a linear nearest-zone search filtered by
// surface code.
//
// Channel   Dir  Beat content
// s_axis    in   tuser: operation; tdata: posture, slot, present, uses, surface,
//                x, y, z (zone write or query)
// m_axis    out  tuser: found; tdata: nearest slot, squared distance
//
// A write beat updates the table as it is accepted. A query reads
// min(ZONES_PER_POSTURE, 8) slots, one memory read per slot into the shared
// distance pipeline, then drains it and posts the result; a query with an
// out-of-range posture skips the scan. After reset a clearing pass writes
// every table entry with s_axis_tready low. A result held on m_axis does not
// stop new beats; only the next query result waits for it to be taken.
// ----------------------------------------------------------------------------
module nearest_zone_search_with_surface_filter_top
    import nzs_pkg::*;
#(
    parameter int ZONES_PER_POSTURE = 8,
    parameter int POSTURE_COUNT     = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [2:0] posture, [5:3] zone_slot, [6] zone_present, [7] uses_surface,
    // [10:8] surface, [26:11] pos_x, [42:27] pos_y, [58:43] pos_z, rest zero
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // [0] operation
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [2:0] nearest_slot, [36:3] nearest_distance_sq, rest zero
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // [0] found
    output logic [0:0]            m_axis_tuser
);

    localparam int DEPTH  = ZONES_PER_POSTURE * POSTURE_COUNT;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SCAN_N = (ZONES_PER_POSTURE < SLOT_COUNT) ? ZONES_PER_POSTURE : SLOT_COUNT;

    // Input beat fields
    logic                      w_op;
    logic [POSTURE_W-1:0]      w_posture;
    logic [SLOT_W-1:0]         w_slot;
    logic                      w_present;
    logic                      w_uses;
    logic [SURF_W-1:0]         w_surface;
    logic signed [COORD_W-1:0] w_x, w_y, w_z;

    assign w_op      = s_axis_tuser[0];
    assign w_posture = s_axis_tdata[2:0];
    assign w_slot    = s_axis_tdata[5:3];
    assign w_present = s_axis_tdata[6];
    assign w_uses    = s_axis_tdata[7];
    assign w_surface = s_axis_tdata[10:8];
    assign w_x       = s_axis_tdata[26:11];
    assign w_y       = s_axis_tdata[42:27];
    assign w_z       = s_axis_tdata[58:43];

    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_addr;
    logic [AW-1:0]       r_scan_addr;
    logic [SLOT_W-1:0]   r_slot_cnt;
    logic                r_v1;
    logic [SLOT_W-1:0]   r_slot1;
    t_hit                r_hit;
    t_zone               r_mem [DEPTH];
    t_zone               r_rd_data;
    logic                r_found;
    logic [SLOT_W-1:0]   r_best_slot;
    logic [DIST_W-1:0]   r_best_d;
    logic                r_m_tvalid;
    logic [M_TDATA_W-1:0] r_m_tdata;
    logic                r_m_tuser;

    logic                w_in_acc;
    logic                w_post_ok;
    logic                w_slot_ok;
    logic                w_scan_last;
    logic                w_out_free;
    logic                w_we;
    logic [AW-1:0]       w_we_addr;
    t_zone               w_we_data;
    t_dist_res           w_res;
    logic                w_busy;
    logic                w_take;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid & s_axis_tready;
    assign w_post_ok     = int'(w_posture) < POSTURE_COUNT;
    assign w_slot_ok     = int'(w_slot) < ZONES_PER_POSTURE;
    assign w_scan_last   = (r_slot_cnt == SLOT_W'(SCAN_N - 1));
    assign w_out_free    = !r_m_tvalid || m_axis_tready;

    // Table write port: clearing pass or a write beat
    always_comb begin
        w_we      = 1'b0;
        w_we_addr = r_clr_addr;
        w_we_data = '0;
        if (r_state == ST_CLEAR) begin
            w_we = 1'b1;
        end else if (w_in_acc && (w_op == OP_WRITE) && w_post_ok && w_slot_ok) begin
            w_we                   = 1'b1;
            w_we_addr              = AW'(int'(w_posture) * ZONES_PER_POSTURE + int'(w_slot));
            w_we_data.valid        = w_present;
            w_we_data.uses_surface = w_uses;
            w_we_data.surface      = w_surface;
            w_we_data.x            = w_x;
            w_we_data.y            = w_y;
            w_we_data.z            = w_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_we_addr] <= w_we_data;
        end
        r_rd_data <= r_mem[r_scan_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (w_in_acc && (w_op == OP_QUERY)) begin
                    n_state = w_post_ok ? ST_SCAN : ST_RESULT;
                end
            end
            ST_SCAN: begin
                if (w_scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!r_v1 && !w_busy) n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (w_out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_v1       <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_v1 <= (r_state == ST_SCAN);
            if ((r_state == ST_RESULT) && w_out_free) begin
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // Scan sequencer: one slot read per cycle
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_scan_addr     <= AW'(int'(w_posture) * ZONES_PER_POSTURE);
            r_slot_cnt      <= '0;
            r_hit.x         <= w_x;
            r_hit.y         <= w_y;
            r_hit.z         <= w_z;
            r_hit.surface   <= w_surface;
        end else if (r_state == ST_SCAN) begin
            r_scan_addr <= r_scan_addr + 1'b1;
            r_slot_cnt  <= r_slot_cnt + 1'b1;
        end
        r_slot1 <= r_slot_cnt;
    end

    nzs_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1),
        .i_slot  (r_slot1),
        .i_entry (r_rd_data),
        .i_hit   (r_hit),
        .o_res   (w_res),
        .o_busy  (w_busy)
    );

    // Later slots win ties
    assign w_take = w_res.valid && w_res.eligible && (!r_found || (w_res.dist_sq <= r_best_d));

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_op == OP_QUERY)) begin
            r_found     <= 1'b0;
            r_best_slot <= '0;
            r_best_d    <= '0;
        end else if (w_take) begin
            r_found     <= 1'b1;
            r_best_slot <= w_res.slot;
            r_best_d    <= w_res.dist_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_RESULT) && w_out_free) begin
            r_m_tdata <= {{M_PAD_W{1'b0}}, r_best_d, r_best_slot};
            r_m_tuser <= r_found;
        end
    end

    assign m_axis_tvalid   = r_m_tvalid;
    assign m_axis_tdata    = r_m_tdata;
    assign m_axis_tuser[0] = r_m_tuser;

endmodule
